// ===== sv/pwtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwtm_pkg
// Shared types and constants of the polyphonic wavetable mixer.
// ----------------------------------------------------------------------------
package pwtm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 10;
  localparam int ENV_W      = 17;
  localparam int INTERVAL_W = 16;
  localparam int KEY_W      = 24;
  localparam int VSEL_W     = 5;
  localparam int WADDR_W    = 10;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;

  // |wave| * level * 32 fits in 31 bits; quotients are clamped to 17 bits,
  // which already drives any 16-bit mix into saturation.
  localparam int DIVIDEND_W = 31;
  localparam int QUOT_W     = 17;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_WAVE   = 2'd1,
    REQ_LENGTH = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_LMAX    = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_t;

  localparam logic [INTERVAL_W-1:0] ATTACK_RST  = 16'd16;
  localparam logic [INTERVAL_W-1:0] RELEASE_RST = 16'd80;
  localparam logic [LEVEL_W-1:0]    LMAX_RST    = 10'd100;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PHASE = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_ACC   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

// ===== sv/pwtm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwtm_div
// Restoring divider, one quotient bit per cycle, quotient clamped to 17 bits.
// ----------------------------------------------------------------------------
module pwtm_div
  import pwtm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [LEVEL_W-1:0]    divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic [DIVIDEND_W-1:0] rem_r;
  logic [DIVIDEND_W-1:0] den_r;
  logic [QUOT_W-1:0]     q_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic                  ovf_r;
  logic                  ge;

  assign ge = (rem_r >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_W - 1);
        rem_r  <= dividend;
        den_r  <= DIVIDEND_W'(divisor) << (QUOT_W - 1);
        ovf_r  <= (dividend >= (DIVIDEND_W'(divisor) << QUOT_W));
        q_r    <= '0;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - den_r;
        end
        q_r   <= {q_r[QUOT_W-2:0], ge};
        den_r <= den_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = ovf_r ? {QUOT_W{1'b1}} : q_r;

endmodule

// ===== sv/polyphonic_wavetable_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_wavetable_mixer
// Wavetable voices with linear attack/release envelopes, mixed one voice at
// a time into an incoming sample through a shared multiply/divide datapath.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid/in_tready    tdata fields, tuser = request kind
// out_      master     out_tvalid/out_tready  mixed sample
// cfg_      slave      cfg_valid/cfg_ready    register index and write data
//
// A load item (wave word or wave length) is taken while the mixer is idle. A
// tick item walks the voices in order: a silent voice passes the phase and
// accumulate steps, a sounding voice also the multiply step and the shared
// bit-serial divider (17 quotient bits).
// Reset is synchronous and active low; the wave memory is not cleared.
// The finished sample waits in an output register; in_tready stays low only
// while a tick is being mixed or its sample cannot yet be handed over.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_mixer
  import pwtm_pkg::*;
#(
  parameter int VOICES     = 24,
  parameter int WAVE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [15:0] mix_in, [16] buffer_start, [40:17] key_vector, [45:41] voice_sel,
  // [55:46] wave_addr, [71:56] wave_value
  input  logic [71:0]          in_tdata,
  // [1:0] req_type
  input  logic [REQ_W-1:0]     in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [15:0] mix_out
  output logic [SAMPLE_W-1:0]  out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [INTERVAL_W-1:0] cfg_data
);

  localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int PW        = $clog2(WAVE_DEPTH);
  localparam int LW        = $clog2(WAVE_DEPTH + 1);
  localparam int MEM_DEPTH = VOICES * WAVE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SW        = 7;   // voice_sel widened for the range check

  // Input fields.
  logic signed [SAMPLE_W-1:0] mix_in;
  logic                       buffer_start;
  logic [KEY_W-1:0]           key_vector;
  logic [VSEL_W-1:0]          voice_sel;
  logic [WADDR_W-1:0]         wave_addr;
  logic [SAMPLE_W-1:0]        wave_value;
  req_t                       req;

  assign mix_in       = in_tdata[15:0];
  assign buffer_start = in_tdata[16];
  assign key_vector   = in_tdata[40:17];
  assign voice_sel    = in_tdata[45:41];
  assign wave_addr    = in_tdata[55:46];
  assign wave_value   = in_tdata[71:56];
  assign req          = req_t'(in_tuser);

  // Configuration registers.
  logic [INTERVAL_W-1:0] attack_r;
  logic [INTERVAL_W-1:0] release_r;
  logic [LEVEL_W-1:0]    lmax_cfg_r;
  logic [LEVEL_W-1:0]    lmax;

  assign cfg_ready = 1'b1;
  // A zero maximum behaves as one, both as divisor and as clamp.
  assign lmax = (lmax_cfg_r == '0) ? LEVEL_W'(1) : lmax_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r   <= ATTACK_RST;
      release_r  <= RELEASE_RST;
      lmax_cfg_r <= LMAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ATTACK:  attack_r   <= cfg_data;
        CFG_RELEASE: release_r  <= cfg_data;
        CFG_LMAX:    lmax_cfg_r <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-voice state and control.
  logic [LW-1:0]      len_r   [VOICES];
  logic [PW-1:0]      phase_r [VOICES];
  logic [ENV_W-1:0]   env_r   [VOICES];
  logic [LEVEL_W-1:0] level_r [VOICES];
  logic [KEY_W-1:0]   keys_r;
  logic [VOICES-1:0]  key_on;

  state_t                     state_r;
  logic [VW-1:0]              voice_r;
  logic signed [SAMPLE_W-1:0] acc_r;
  logic [DIVIDEND_W-1:0]      prod_r;
  logic                       neg_r;
  logic                       start_r;
  logic signed [SAMPLE_W-1:0] out_r;
  logic                       out_valid_r;
  logic                       load_out;

  // Voices beyond the key vector are never keyed on.
  for (genvar v = 0; v < VOICES; v++) begin : g_key
    if (v < KEY_W) begin : g_on
      assign key_on[v] = keys_r[v];
    end else begin : g_off
      assign key_on[v] = 1'b0;
    end
  end

  // Wave memory: one write port for loads, one registered read port.
  logic [SAMPLE_W-1:0] wave_mem [MEM_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [SW-1:0]       vsel_ext;
  logic                vsel_ok;
  logic                in_acc;

  assign in_acc   = in_tvalid && in_tready;
  assign vsel_ext = SW'(voice_sel);
  assign vsel_ok  = (vsel_ext < SW'(VOICES));
  assign wr_addr  = AW'(vsel_ext) * AW'(WAVE_DEPTH) + AW'(wave_addr);

  // Phase advance of the current voice.
  logic [PW:0] nxt_raw;
  logic [PW-1:0] nxt;

  assign nxt_raw = {1'b0, phase_r[voice_r]} + 1'b1;
  assign nxt = ((nxt_raw >= (PW+1)'(len_r[voice_r])) ||
                (nxt_raw >= (PW+1)'(WAVE_DEPTH))) ? '0 : nxt_raw[PW-1:0];
  assign rd_addr = AW'(voice_r) * AW'(WAVE_DEPTH) + AW'(nxt);

  always_ff @(posedge clk) begin
    if (in_acc && req == REQ_WAVE && vsel_ok &&
        (32'(wave_addr) < 32'(WAVE_DEPTH))) begin
      wave_mem[wr_addr] <= wave_value;
    end
    if (state_r == S_PHASE) begin
      rd_data_r <= wave_mem[rd_addr];
    end
  end

  // Clamped wave length from a length load.
  logic [LW-1:0] len_in;

  always_comb begin
    if (wave_value[15] || wave_value == '0) begin
      len_in = LW'(1);
    end else if (wave_value[14:0] > 15'(WAVE_DEPTH)) begin
      len_in = LW'(WAVE_DEPTH);
    end else begin
      len_in = LW'(wave_value[14:0]);
    end
  end

  // Shared divider.
  logic              div_done;
  logic [QUOT_W-1:0] quot;

  pwtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (prod_r),
    .divisor  (lmax),
    .done     (div_done),
    .quotient (quot)
  );

  // Magnitude of the wave word times level times 32; the sign is kept apart
  // so the divide truncates toward zero.
  logic [SAMPLE_W-1:0] wmag;
  assign wmag = rd_data_r[15] ? (~rd_data_r + 1'b1) : rd_data_r;

  // Add of the voice contribution with saturation.
  logic signed [QUOT_W:0]     contrib;
  logic signed [QUOT_W+1:0]   sum;
  logic signed [SAMPLE_W-1:0] sum_sat;
  logic                       sounding;

  assign sounding = (level_r[voice_r] != '0);

  always_comb begin
    if (!sounding) begin
      contrib = '0;
    end else if (neg_r) begin
      contrib = -$signed({1'b0, quot});
    end else begin
      contrib = $signed({1'b0, quot});
    end
    sum = (QUOT_W+2)'(acc_r) + (QUOT_W+2)'(contrib);
    if (sum > (QUOT_W+2)'(32767)) begin
      sum_sat = 16'sh7fff;
    end else if (sum < -(QUOT_W+2)'(32768)) begin
      sum_sat = -16'sh8000;
    end else begin
      sum_sat = sum[SAMPLE_W-1:0];
    end
  end

  // Envelope step of the current voice.
  logic [ENV_W-1:0]   env_inc;
  logic [LEVEL_W:0]   lvl_up;
  logic [ENV_W-1:0]   env_nxt;
  logic [LEVEL_W-1:0] lvl_nxt;

  assign env_inc = env_r[voice_r] + 1'b1;
  assign lvl_up  = {1'b0, level_r[voice_r]} + 1'b1;

  always_comb begin
    env_nxt = env_inc;
    lvl_nxt = level_r[voice_r];
    if (key_on[voice_r]) begin
      if (env_inc > ENV_W'(attack_r)) begin
        env_nxt = '0;
        lvl_nxt = (lvl_up > {1'b0, lmax}) ? lmax : lvl_up[LEVEL_W-1:0];
      end
    end else if (env_inc > ENV_W'(release_r)) begin
      env_nxt = '0;
      if (level_r[voice_r] != '0) begin
        lvl_nxt = level_r[voice_r] - 1'b1;
      end
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // The finished sample moves into the output register once it is free or
  // is being handed over in the same cycle.
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      voice_r     <= '0;
      keys_r      <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        len_r[v]   <= LW'(1);
        phase_r[v] <= '0;
        env_r[v]   <= '0;
        level_r[v] <= '0;
      end
    end else begin
      start_r <= 1'b0;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (req == REQ_LENGTH && vsel_ok) begin
              len_r[vsel_ext[VW-1:0]] <= len_in;
            end
            if (req == REQ_TICK) begin
              acc_r   <= mix_in;
              voice_r <= '0;
              state_r <= S_PHASE;
              if (buffer_start) begin
                keys_r <= key_vector;
              end
            end
          end
        end
        S_PHASE: begin
          phase_r[voice_r] <= nxt;
          state_r <= sounding ? S_MUL : S_ACC;
        end
        S_MUL: begin
          prod_r  <= (DIVIDEND_W'(wmag) * DIVIDEND_W'(level_r[voice_r])) << 5;
          neg_r   <= rd_data_r[15];
          start_r <= 1'b1;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          acc_r            <= sum_sat;
          env_r[voice_r]   <= env_nxt;
          level_r[voice_r] <= lvl_nxt;
          if (32'(voice_r) == VOICES - 1) begin
            state_r <= S_DONE;
          end else begin
            voice_r <= voice_r + 1'b1;
            state_r <= S_PHASE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_r   <= acc_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // A new sample appears only when a tick has finished its last voice.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("output sample raised outside the final step of a tick");

  // The divider only reports completion while the sequencer waits on it.
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  // The voice counter never runs past the last voice while mixing.
  a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (32'(voice_r) < VOICES))
    else $error("voice index out of range");

endmodule
